// ----- rtl/ghash_gf128_accumulator_top_defines.svh -----
// Assertion macros shared by the GHASH accumulator checker.
`ifndef GHASH_GF128_ACCUMULATOR_TOP_DEFINES_SVH
`define GHASH_GF128_ACCUMULATOR_TOP_DEFINES_SVH

// Clocked check, quiet while reset is asserted
`define GHASH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked check that also holds while reset is asserted
`define GHASH_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ----- rtl/ghash_pkg.sv -----
// Shared types and constants for the GHASH GF(2^128) accumulator.
package ghash_pkg;

    localparam int HALF_W  = 64;
    localparam int BLOCK_W = 2 * HALF_W;
    localparam int CFG_INDEX_W = 1;

    // One field element, GCM bit order: bit 127 is GCM bit 0
    typedef logic [BLOCK_W-1:0] gf_elem_t;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KEY_HIGH = 1'b0,
        REG_KEY_LOW  = 1'b1
    } cfg_reg_t;

endpackage

// ----- rtl/ghash_gfmul.sv -----
// Combinational GF(2^128) multiplier in GCM bit order (carry-less product plus reduction).
module ghash_gfmul
    import ghash_pkg::*;
(
    input  gf_elem_t x,
    input  gf_elem_t h,
    output gf_elem_t z
);

    localparam int PROD_W = 2 * BLOCK_W;
    localparam int FOLD_W = BLOCK_W + 8;

    // GCM order puts the x^0 coefficient in the top bit; flip to normal order
    function automatic gf_elem_t bit_rev(input gf_elem_t v);
        gf_elem_t r;
        for (int k = 0; k < BLOCK_W; k++)
        begin
            r[k] = v[BLOCK_W-1-k];
        end
        return r;
    endfunction

    gf_elem_t              a;
    gf_elem_t              b;
    logic [PROD_W-1:0]     pp [BLOCK_W];
    logic [PROD_W-1:0]     prod;
    logic [FOLD_W-1:0]     hi1;
    logic [FOLD_W-1:0]     fold1;
    logic [FOLD_W-1:0]     hi2;
    logic [FOLD_W-1:0]     fold2;
    gf_elem_t              red;

    assign a = bit_rev(x);
    assign b = bit_rev(h);

    // Partial products: one shifted copy of b per bit of a
    always_comb
    begin
        for (int i = 0; i < BLOCK_W; i++)
        begin
            pp[i] = a[i] ? ({{BLOCK_W{1'b0}}, b} << i) : '0;
        end
    end

    // XOR of the partial products gives the carry-less product
    always_comb
    begin
        prod = '0;
        for (int i = 0; i < BLOCK_W; i++)
        begin
            prod = prod ^ pp[i];
        end
    end

    // Reduce modulo x^128 + x^7 + x^2 + x + 1: x^128 folds to x^7 + x^2 + x + 1
    always_comb
    begin
        hi1   = {8'd0, prod[PROD_W-1:BLOCK_W]};
        fold1 = hi1 ^ (hi1 << 1) ^ (hi1 << 2) ^ (hi1 << 7);
        // Second fold: at most six bits spill past x^127
        hi2   = {{BLOCK_W{1'b0}}, fold1[FOLD_W-1:BLOCK_W]};
        fold2 = hi2 ^ (hi2 << 1) ^ (hi2 << 2) ^ (hi2 << 7);
        red   = prod[BLOCK_W-1:0] ^ fold1[BLOCK_W-1:0] ^ fold2[BLOCK_W-1:0];
    end

    assign z = bit_rev(red);

endmodule

// ----- rtl/ghash_gf128_accumulator_top.sv -----
// GHASH accumulator top level: input stage, GF(2^128) multiply-accumulate, hash output register.
// Accepts one 128-bit word per clock while in_stall is low. A word is latched into the input
// stage; as it leaves that stage, the accumulator (cleared first when first_block is set) is
// XORed with it and multiplied by H in a single combinational GF(2^128) multiplier; that one
// multiplier path between the input stage and the accumulator sets the clock rate. A word
// with last_block set leaves the input stage only when the hash output register is free, and
// its hash is registered there and shown on hash_high/hash_low. While a hash word is held
// under out_stall, words without last_block keep flowing through the accumulator; in_stall
// rises only once the next word with last_block waits in the input stage. The accumulator keeps
// its value after a hash is emitted. Load H through cfg_write_en/cfg_index/cfg_data (index 0
// is the upper half, 1 the lower half) only while no word is in flight; H resets to zero.
module ghash_gf128_accumulator_top
    import ghash_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write port
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [HALF_W-1:0]      cfg_data,
    // input words
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [HALF_W-1:0]      block_high,
    input  logic [HALF_W-1:0]      block_low,
    input  logic                   first_block,
    input  logic                   last_block,
    // hash words
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [HALF_W-1:0]      hash_high,
    output logic [HALF_W-1:0]      hash_low
);

    gf_elem_t key_reg;
    gf_elem_t key_next;
    gf_elem_t acc_reg;
    gf_elem_t acc_next;

    logic     s1_valid_reg;
    logic     s1_valid_next;
    logic     s1_first_reg;
    logic     s1_last_reg;
    gf_elem_t s1_block_reg;

    logic     out_valid_reg;
    logic     out_valid_next;
    gf_elem_t out_hash_reg;
    gf_elem_t out_hash_next;

    logic     in_take;
    logic     out_free;
    logic     s1_adv;
    logic     emit;
    gf_elem_t mul_in;
    gf_elem_t product;

    // Handshake
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && (!s1_last_reg || out_free);
    assign emit     = s1_adv && s1_last_reg;
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_take  = in_valid && !in_stall;

    // Key register writes
    always_comb
    begin
        key_next = key_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_KEY_HIGH: key_next[BLOCK_W-1:HALF_W] = cfg_data;
                REG_KEY_LOW:  key_next[HALF_W-1:0]       = cfg_data;
                default:      key_next = key_reg;
            endcase
        end
    end

    // Multiply-accumulate
    assign mul_in = (s1_first_reg ? '0 : acc_reg) ^ s1_block_reg;

    ghash_gfmul u_gfmul (
        .x (mul_in),
        .h (key_reg),
        .z (product)
    );

    assign acc_next = s1_adv ? product : acc_reg;

    // Stage and output control
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_hash_next  = out_hash_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_hash_next  = product;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            key_reg       <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
            key_reg       <= key_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_block_reg <= {block_high, block_low};
            s1_first_reg <= first_block;
            s1_last_reg  <= last_block;
        end
        out_hash_reg <= out_hash_next;
    end

    assign out_valid = out_valid_reg;
    assign hash_high = out_hash_reg[BLOCK_W-1:HALF_W];
    assign hash_low  = out_hash_reg[HALF_W-1:0];

endmodule

// ----- rtl/ghash_checker.sv -----
// Port-level checks for the GHASH accumulator, bound to the top level.
`include "ghash_gf128_accumulator_top_defines.svh"

module ghash_checker
    import ghash_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   cfg_write_en,
    input logic [CFG_INDEX_W-1:0] cfg_index,
    input logic [HALF_W-1:0]      cfg_data,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic [HALF_W-1:0]      block_high,
    input logic [HALF_W-1:0]      block_low,
    input logic                   first_block,
    input logic                   last_block,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [HALF_W-1:0]      hash_high,
    input logic [HALF_W-1:0]      hash_low
);

    // A held hash word stays put
    `GHASH_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(hash_high) && $stable(hash_low), "hash word changed while stalled")

    // The input side only stalls behind a hash word that is itself stalled
    `GHASH_ASSERT(a_in_stall_cause, in_stall |-> out_valid && out_stall, "input stalled without a held hash word")

    // A new hash word traces back to an accepted last word, through the input stage and output register
    `GHASH_ASSERT(a_out_origin, $rose(out_valid) |-> $past(in_valid && !in_stall && last_block, 2), "hash word without a last word")

    // Nothing is offered or held back during reset
    `GHASH_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !out_valid && !in_stall, "handshake active in reset")

endmodule

bind ghash_gf128_accumulator_top ghash_checker u_ghash_checker (.*);

// ----- bench/testbench.sv -----
// Self-checking testbench for the GHASH GF(2^128) accumulator top level.
`timescale 1ns / 100ps

module testbench;
    import ghash_pkg::*;

    localparam int HOLD_LEN   = 64;    // long output hold-off for the fill-up test
    localparam int DRAIN      = 4;     // cycles for a word without last_block to settle
    localparam int QUIET_MAX  = 4000;  // watchdog: cycles with no word moving
    localparam int PHASE_LEN  = 410;   // random words per idling phase
    localparam int PRINT_MAX  = 30;

    localparam logic [HALF_W-1:0] ONES    = {HALF_W{1'b1}};
    localparam logic [HALF_W-1:0] ID_HIGH = 64'h8000_0000_0000_0000;  // GCM "one"
    localparam gf_elem_t          GF_R    = {8'he1, 120'h0};

    typedef struct packed {
        logic [HALF_W-1:0] blk_high;
        logic [HALF_W-1:0] blk_low;
        logic              first;
        logic              last;
    } block_word_t;

    typedef struct packed {
        logic              load_key;
        logic [HALF_W-1:0] key_high;
        logic [HALF_W-1:0] key_low;
        logic [HALF_W-1:0] blk_high;
        logic [HALF_W-1:0] blk_low;
        logic              first;
        logic              last;
        logic              golden_ok;
        logic [HALF_W-1:0] golden_high;
        logic [HALF_W-1:0] golden_low;
    } stim_row_t;

    // directed words; a typed hash only where it is obvious (zero key, identity key)
    localparam int N_ROWS = 20;
    stim_row_t directed_rows [0:N_ROWS-1] = '{
        '{1'b0, 64'h0, 64'h0, ONES, ONES, 1'b1, 1'b1, 1'b1, 64'h0, 64'h0},
        '{1'b0, 64'h0, 64'h0, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
          1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
        '{1'b0, 64'h0, 64'h0, ONES, ONES, 1'b0, 1'b1, 1'b1, 64'h0, 64'h0},
        '{1'b1, ID_HIGH, 64'h0, ONES, ONES, 1'b1, 1'b1, 1'b1, ONES, ONES},
        '{1'b0, 64'h0, 64'h0, 64'h0, 64'h0, 1'b1, 1'b1, 1'b1, 64'h0, 64'h0},
        '{1'b0, 64'h0, 64'h0, ID_HIGH, 64'h1, 1'b1, 1'b1, 1'b1, ID_HIGH, 64'h1},
        '{1'b0, 64'h0, 64'h0, 64'hdead_beef_0000_0001, 64'h8000_0000_cafe_f00d,
          1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
        '{1'b0, 64'h0, 64'h0, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
          1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
        '{1'b0, 64'h0, 64'h0, 64'h0f0f_0f0f_0f0f_0f0f, 64'hf0f0_f0f0_f0f0_f0f0,
          1'b0, 1'b1, 1'b0, 64'h0, 64'h0},
        '{1'b0, 64'h0, 64'h0, ONES, 64'h0, 1'b0, 1'b1, 1'b0, 64'h0, 64'h0},
        '{1'b1, ONES, ONES, 64'h0123_4567_89ab_cdef, 64'h0011_2233_4455_6677,
          1'b1, 1'b1, 1'b0, 64'h0, 64'h0},
        '{1'b0, 64'h0, 64'h0, ONES, ONES, 1'b1, 1'b1, 1'b0, 64'h0, 64'h0},
        '{1'b0, 64'h0, 64'h0, ID_HIGH, 64'h0, 1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
        '{1'b1, 64'h0, 64'h1, 64'h1, ID_HIGH, 1'b0, 1'b0, 1'b0, 64'h0, 64'h0},
        '{1'b0, 64'h0, 64'h0, 64'h0, 64'h1, 1'b0, 1'b1, 1'b0, 64'h0, 64'h0},
        '{1'b1, 64'h66e9_4bd4_ef8a_2c3b, 64'h884c_fa59_ca34_2b2e,
          64'h0388_dace_60b6_a392, 64'hf328_c2b9_71b2_fe78,
          1'b1, 1'b0, 1'b0, 64'h0, 64'h0},
        '{1'b0, 64'h0, 64'h0, 64'h0, 64'h80, 1'b0, 1'b1, 1'b0, 64'h0, 64'h0},
        '{1'b1, 64'h0, 64'h0, 64'h1234_5678_9abc_def0, 64'h0fed_cba9_8765_4321,
          1'b1, 1'b1, 1'b1, 64'h0, 64'h0},
        '{1'b0, 64'h0, 64'h0, ONES, ONES, 1'b0, 1'b1, 1'b1, 64'h0, 64'h0},
        '{1'b0, 64'h0, 64'h0, 64'h0, 64'h0, 1'b1, 1'b1, 1'b1, 64'h0, 64'h0}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [HALF_W-1:0]      cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [HALF_W-1:0]      block_high;
    logic [HALF_W-1:0]      block_low;
    logic                   first_block;
    logic                   last_block;
    logic                   out_valid;
    logic                   out_stall;
    logic [HALF_W-1:0]      hash_high;
    logic [HALF_W-1:0]      hash_low;

    // predictor state
    gf_elem_t ghash_acc;
    gf_elem_t hash_key;
    gf_elem_t hash_expected_q [$];
    gf_elem_t hash_want;

    int gap_pct        = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int holds_served   = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;
    int mismatch_count = 0;

    ghash_gf128_accumulator_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .block_high   (block_high),
        .block_low    (block_low),
        .first_block  (first_block),
        .last_block   (last_block),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hash_high    (hash_high),
        .hash_low     (hash_low)
    );

    always #5 clk = ~clk;

    // x * h in GF(2^128), GCM bit order: bit 127 of x is taken first
    function automatic gf_elem_t gf_times_key(gf_elem_t x, gf_elem_t h);
        gf_elem_t prod;
        gf_elem_t v;
        prod = '0;
        v    = h;
        for (int i = BLOCK_W - 1; i >= 0; i--)
        begin
            if (x[i])
                prod ^= v;
            v = v[0] ? ((v >> 1) ^ GF_R) : (v >> 1);
        end
        return prod;
    endfunction

    function automatic logic [HALF_W-1:0] rand_half();
        return {$urandom(), $urandom()};
    endfunction

    // key halves: mostly random, sometimes zero, all ones or the GCM identity
    function automatic logic [HALF_W-1:0] pick_key_half();
        case ($urandom_range(7))
            0:       return '0;
            1:       return ONES;
            2:       return ID_HIGH;
            default: return rand_half();
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [HALF_W-1:0] got,
                                   input logic [HALF_W-1:0] want);
        if (mismatch_count < PRINT_MAX)
            $display("%0t ERROR %s: got %h want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // one word through the handshake, then absorbed into the predictor
    task automatic send_word(input block_word_t w, input bit golden_ok,
                             input gf_elem_t golden);
        bit took;
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        block_high  <= w.blk_high;
        block_low   <= w.blk_low;
        first_block <= w.first;
        last_block  <= w.last;
        took = 1'b0;
        while (!took)
        begin
            @(negedge clk);
            took = !in_stall;
            @(posedge clk);
        end
        if (w.first)
            ghash_acc = '0;
        ghash_acc = gf_times_key(ghash_acc ^ {w.blk_high, w.blk_low}, hash_key);
        if (w.last)
            hash_expected_q.push_back(golden_ok ? golden : ghash_acc);
    endtask

    // stop sending and let the block drain before a key write
    task automatic quiet_down();
        in_valid <= 1'b0;
        while (hash_expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_key_reg(input cfg_reg_t idx, input logic [HALF_W-1:0] v);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_KEY_HIGH: hash_key[BLOCK_W-1:HALF_W] = v;
            REG_KEY_LOW:  hash_key[HALF_W-1:0]       = v;
            default: ;
        endcase
    endtask

    // mostly well-formed messages with random content, some stray words
    task automatic run_random_phase(input int sender_gap, input int recv_stall, input int count);
        int          sent;
        int          len;
        block_word_t w;
        gap_pct         = sender_gap;
        recv_stall_pct <= recv_stall;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(19) == 0)
            begin
                quiet_down();
                if ($urandom_range(3) != 0)
                    write_key_reg(REG_KEY_HIGH, pick_key_half());
                if ($urandom_range(3) != 0)
                    write_key_reg(REG_KEY_LOW, pick_key_half());
            end
            if ($urandom_range(99) < 15)
            begin
                w = {rand_half(), rand_half(), 1'($urandom()), 1'($urandom())};
                send_word(w, 1'b0, '0);
                sent++;
            end
            else
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(16, 7) : $urandom_range(5, 1);
                for (int k = 0; k < len; k++)
                begin
                    w = {rand_half(), rand_half(), 1'(k == 0), 1'(k == len - 1)};
                    send_word(w, 1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (holds_served != hold_requests)
        begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_LEN;
            out_stall    <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // hash check and watchdog; sampled mid-cycle, so what is seen is what the edge takes
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (out_valid && !out_stall)
            begin
                if (hash_expected_q.size() == 0)
                    report_mismatch("hash word with none expected", hash_high, hash_low);
                else
                begin
                    hash_want = hash_expected_q.pop_front();
                    if (hash_high !== hash_want[BLOCK_W-1:HALF_W])
                        report_mismatch("hash_high", hash_high, hash_want[BLOCK_W-1:HALF_W]);
                    if (hash_low !== hash_want[HALF_W-1:0])
                        report_mismatch("hash_low", hash_low, hash_want[HALF_W-1:0]);
                end
            end
            if (quiet_cycles >= QUIET_MAX)
            begin
                $display("%0t watchdog: no word moved for %0d cycles", $realtime, QUIET_MAX);
                $display("ghash_gf128_accumulator_top: mismatch");
                $finish;
            end
        end
    end

    // main sequence
    initial
    begin
        block_word_t w;
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = REG_KEY_HIGH;
        cfg_data     = '0;
        in_valid     = 1'b0;
        block_high   = '0;
        block_low    = '0;
        first_block  = 1'b0;
        last_block   = 1'b0;
        ghash_acc    = '0;
        hash_key     = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words, light idling on both sides
        gap_pct         = 16;
        recv_stall_pct <= 16;
        for (int r = 0; r < N_ROWS; r++)
        begin
            if (directed_rows[r].load_key)
            begin
                quiet_down();
                write_key_reg(REG_KEY_HIGH, directed_rows[r].key_high);
                write_key_reg(REG_KEY_LOW, directed_rows[r].key_low);
            end
            w = {directed_rows[r].blk_high, directed_rows[r].blk_low,
                 directed_rows[r].first, directed_rows[r].last};
            send_word(w, directed_rows[r].golden_ok,
                      {directed_rows[r].golden_high, directed_rows[r].golden_low});
        end

        // fill-up: receiver holds off while one-word hashes keep coming
        quiet_down();
        write_key_reg(REG_KEY_HIGH, rand_half());
        write_key_reg(REG_KEY_LOW, rand_half());
        gap_pct         = 0;
        recv_stall_pct <= 0;
        hold_requests  <= hold_requests + 1;
        for (int k = 0; k < 24; k++)
        begin
            w = {rand_half(), rand_half(), 1'b1, 1'b1};
            send_word(w, 1'b0, '0);
        end

        // random traffic in three idling phases
        run_random_phase(16, 76, PHASE_LEN);
        run_random_phase(76, 16, PHASE_LEN);
        run_random_phase(0, 0, PHASE_LEN);

        // drain; the watchdog bounds this wait
        in_valid <= 1'b0;
        while (hash_expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN + 4) @(posedge clk);

        if (mismatch_count == 0)
            $display("ghash_gf128_accumulator_top: match");
        else
            $display("ghash_gf128_accumulator_top: mismatch");
        $finish;
    end

endmodule
